// File: rtl/core/asfyr_pkg.sv
// Shared types and constants for the Ackermann steering-from-yaw-rate block.
// Holds the transfer payload structs, the CORDIC stage struct and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package asfyr_pkg;

   // Transfer payloads.
   typedef struct packed {
      logic signed [15:0] velocity;
      logic signed [15:0] turn_rate;
   } req_type;

   typedef struct packed {
      logic signed [15:0] speed_out;
      logic signed [15:0] steer_angle;
   } rsp_type;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_WHEELBASE = 2'd0;
   localparam logic [1:0] REG_MAX_ANGLE = 2'd1;
   localparam logic [1:0] REG_MIN_SPEED = 2'd2;

   // Reset values: 0.255 m, 0.60 rad, 0.05 m/s.
   localparam logic [15:0] WHEELBASE_RST = 16'd16712;
   localparam logic [14:0] MAX_ANGLE_RST = 15'd9830;
   localparam logic [14:0] MIN_SPEED_RST = 15'd205;

   // Datapath widths. X and Y start below 2^32 in magnitude and grow by the
   // CORDIC gain, so 36 bits leave headroom; Z stays below 2^31.
   localparam int XY_W = 36;
   localparam int Z_W  = 33;

   // atan(2^-i) in Q2.30, truncated.
   localparam int ATAN_LEN = 24;
   localparam logic [30:0] ATAN_TAB [ATAN_LEN] = '{
      31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
      31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
      31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
      31'd262143,    31'd131071,    31'd65535,     31'd32767,
      31'd16383,     31'd8191,      31'd4095,      31'd2047,
      31'd1023,      31'd511,       31'd255,       31'd127
   };

   // One item in flight through the CORDIC chain.
   typedef struct packed {
      logic                   valid;
      logic                   slow;
      logic [15:0]            speed;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_type;

endpackage

// File: rtl/core/ackermann_steering_from_yaw_rate.sv
// Top level of the Ackermann steering-angle pipeline: registers, front end,
// CORDIC chain, rounding and clamping, output skid stage.
// Depends on asfyr_pkg and asfyr_cordic_step.
`timescale 1ns / 1ps

//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  req     | in        | req_valid / req_stall   | req_data: velocity, turn_rate
//  rsp     | out       | rsp_valid / rsp_stall   | rsp_data: speed_out, steer_angle
//  csr     | in        | csr_we (no handshake)   | csr_index, csr_wdata
//
//  One transfer is accepted per cycle while req_stall is low. Stages, in order:
//  input register, multiplier stage, one per CORDIC iteration (at most 24), round and
//  clamp, output register. Reset loads the register defaults and empties the
//  pipeline; nothing else needs clearing. A stall on rsp first fills a one-entry
//  skid register; only then does req_stall rise and the whole pipeline hold.

module ackermann_steering_from_yaw_rate
   import asfyr_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // The arctangent table only covers 24 iterations; more add nothing.
   localparam int NUM_STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

   // Configuration registers.
   logic [15:0] wheelbase_ff;
   logic [14:0] max_angle_ff;
   logic [14:0] min_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheelbase_ff <= WHEELBASE_RST;
         max_angle_ff <= MAX_ANGLE_RST;
         min_speed_ff <= MIN_SPEED_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_WHEELBASE: wheelbase_ff <= csr_wdata;
            REG_MAX_ANGLE: max_angle_ff <= csr_wdata[14:0];
            REG_MIN_SPEED: min_speed_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves as one; it only holds when the skid register is full.
   logic advance;
   logic skid_v_ff;

   assign advance   = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // Input stage. A negative velocity is folded into the yaw rate, so the CORDIC
   // always sees a non-negative X and atan(Y/X) keeps its sign.
   logic               s0_v_ff;
   logic [15:0]        s0_speed_ff;
   logic [16:0]        s0_mag_ff,  s0_mag_in;
   logic signed [16:0] s0_yaw_ff,  s0_yaw_in;
   logic signed [16:0] vel_ext, yaw_ext;

   assign vel_ext = {req_data.velocity[15], req_data.velocity};
   assign yaw_ext = {req_data.turn_rate[15], req_data.turn_rate};

   always_comb begin
      if (req_data.velocity[15]) begin
         s0_mag_in = 17'(-vel_ext);
         s0_yaw_in = -yaw_ext;
      end else begin
         s0_mag_in = 17'(vel_ext);
         s0_yaw_in = yaw_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (advance) begin
         s0_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         s0_speed_ff <= req_data.velocity;
         s0_mag_ff   <= s0_mag_in;
         s0_yaw_ff   <= s0_yaw_in;
      end
   end

   // Multiplier stage: Y = yaw * wheelbase, X = |velocity| << 16, both Q4.28.
   cordic_type         s1_ff, s1_in;
   logic signed [33:0] product;

   assign product = s0_yaw_ff * $signed({1'b0, wheelbase_ff});

   always_comb begin
      s1_in.valid = s0_v_ff;
      s1_in.slow  = (s0_mag_ff <= {2'b00, min_speed_ff});
      s1_in.speed = s0_speed_ff;
      s1_in.x     = $signed({3'b000, s0_mag_ff, 16'h0000});
      s1_in.y     = XY_W'(product);
      s1_in.z     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= s1_in;
      end
   end

   // CORDIC chain, one registered iteration per stage.
   cordic_type chain [NUM_STEPS+1];

   assign chain[0] = s1_ff;

   for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      asfyr_cordic_step #(
         .STEP (k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[k]),
         .stage_out (chain[k+1])
      );
   end

   // Round Q2.30 to Q2.14 with ties up, clamp to the symmetric limit, and force
   // zero for a slow or stopped vehicle.
   cordic_type         last;
   logic signed [Z_W:0] z_round;
   logic signed [17:0]  ang_r;
   logic signed [17:0]  lim;
   logic signed [15:0]  ang_in;
   logic                fin_v_ff;
   rsp_type             fin_ff;

   assign last    = chain[NUM_STEPS];
   assign z_round = (Z_W+1)'(last.z) + (Z_W+1)'(32768);
   assign ang_r   = 18'(z_round >>> 16);
   assign lim     = $signed({3'b000, max_angle_ff});

   always_comb begin
      if (last.slow) begin
         ang_in = '0;
      end else if (ang_r > lim) begin
         ang_in = 16'(lim);
      end else if (ang_r < -lim) begin
         ang_in = 16'(-lim);
      end else begin
         ang_in = 16'(ang_r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (advance) begin
         fin_v_ff <= last.valid;
         fin_ff   <= '{speed_out: last.speed, steer_angle: ang_in};
      end
   end

   // Output register with a one-entry skid register behind it. While the skid
   // entry is empty the final stage always drains: into the output register when
   // it is free or being taken, otherwise into the skid entry.
   logic    out_v_ff;
   rsp_type out_ff;
   rsp_type skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (!rsp_stall) begin
            out_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (out_v_ff && rsp_stall) begin
         if (fin_v_ff) begin
            skid_ff   <= fin_ff;
            skid_v_ff <= 1'b1;
         end
      end else begin
         out_v_ff <= fin_v_ff;
         out_ff   <= fin_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // The skid entry is only ever filled behind a held output.
   assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry holds a transfer while the output is empty");

   // A finished item arriving at a stalled output must land in the skid entry.
   assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && rsp_stall && !skid_v_ff && fin_v_ff) |=> skid_v_ff)
      else $error("finished item dropped at a stalled output");

   // Every delivered angle lies inside the configured limit.
   assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (($signed({rsp_data.steer_angle[15], rsp_data.steer_angle}) <=
                     $signed({2'b00, max_angle_ff})) &&
                    ($signed({rsp_data.steer_angle[15], rsp_data.steer_angle}) >=
                     -$signed({2'b00, max_angle_ff}))))
      else $error("steering angle outside the clamp limit");

endmodule

// File: rtl/core/asfyr_cordic_step.sv
// One registered CORDIC vectoring iteration of the steering pipeline.
// Depends on asfyr_pkg for the stage struct and the arctangent table.
`timescale 1ns / 1ps

module asfyr_cordic_step
   import asfyr_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  cordic_type stage_in,
   output cordic_type stage_out
);

   cordic_type             step_ff;
   cordic_type             step_in;
   logic                   y_pos;
   logic signed [XY_W-1:0] x_sh;
   logic signed [XY_W-1:0] y_sh;
   logic signed [Z_W-1:0]  angle;

   assign x_sh  = stage_in.x >>> STEP;
   assign y_sh  = stage_in.y >>> STEP;
   assign angle = $signed({2'b00, ATAN_TAB[STEP]});
   assign y_pos = !stage_in.y[XY_W-1] && (stage_in.y != '0);

   // Rotate toward the x axis: the sign of Y picks the direction.
   always_comb begin
      step_in = stage_in;
      if (y_pos) begin
         step_in.x = stage_in.x + y_sh;
         step_in.y = stage_in.y - x_sh;
         step_in.z = stage_in.z + angle;
      end else begin
         step_in.x = stage_in.x - y_sh;
         step_in.y = stage_in.y + x_sh;
         step_in.z = stage_in.z - angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else if (advance) begin
         step_ff <= step_in;
      end
   end

   assign stage_out = step_ff;

endmodule
